@@ rtl/core/weighted_fair_slot_arbiter_core_assert.svh @@
// assertion macros for the weighted fair slot arbiter core
// used by the top level; no other dependencies
`ifndef WEIGHTED_FAIR_SLOT_ARBITER_CORE_ASSERT_SVH
`define WEIGHTED_FAIR_SLOT_ARBITER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define WFSA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("wfsa assertion failed");
// next-cycle implication
`define WFSA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("wfsa assertion failed");
`else
`define WFSA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define WFSA_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ rtl/core/wfsa_pkg.sv @@
// shared types and constants of the weighted fair slot arbiter
// no dependencies
package wfsa_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int CLIENT_W   = 64;
  localparam int WEIGHT_W   = 14;
  localparam int VTIME_W    = 64;
  localparam int READY_W    = 8;
  localparam int SLICE_W    = 30;
  localparam int CFG_IDX_W  = 1;
  localparam int DIV_CNT_W  = $clog2(SLICE_W);

  typedef logic [1:0]            op_t;
  typedef logic [1:0]            status_t;
  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [DIV_CNT_W-1:0]  div_cnt_t;

  // request opcodes
  localparam op_t OP_ATTACH     = 2'd0;
  localparam op_t OP_DETACH     = 2'd1;
  localparam op_t OP_SET_WEIGHT = 2'd2;
  localparam op_t OP_DISPATCH   = 2'd3;

  // result status codes
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_NO_SPACE = 2'd1;
  localparam status_t ST_NONE     = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t CFG_SLICE  = 1'd0;
  localparam cfg_idx_t CFG_ENABLE = 1'd1;

  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(700000);
  localparam slot_idx_t          LAST_SLOT   = slot_idx_t'(NUM_SLOTS - 1);
  localparam div_cnt_t           DIV_LAST    = div_cnt_t'(SLICE_W - 1);

  // one slot of the table
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [WEIGHT_W-1:0] weight;
    logic [VTIME_W-1:0]  vtime;
  } slot_entry_t;

  // slot memory access from the sequencer
  typedef struct packed {
    logic        rd_en;
    slot_idx_t   rd_addr;
    logic        wr_en;
    slot_idx_t   wr_addr;
    logic        wr_valid;
    slot_entry_t wr_data;
  } mem_req_t;

  // divider start
  typedef struct packed {
    logic                start;
    logic [SLICE_W-1:0]  dividend;
    logic [WEIGHT_W-1:0] divisor;
  } div_req_t;

endpackage

@@ rtl/core/wfsa_req_if.sv @@
// request channel of the weighted fair slot arbiter
// depends on wfsa_pkg
interface wfsa_req_if;
  logic                           valid;
  logic                           ready;
  wfsa_pkg::op_t                  op;
  logic [wfsa_pkg::CLIENT_W-1:0]  client_id;
  logic [wfsa_pkg::WEIGHT_W-1:0]  client_weight;
  logic [wfsa_pkg::READY_W-1:0]   ready_mask;

  modport source (output valid, output op, output client_id, output client_weight,
                  output ready_mask, input ready);
  modport sink (input valid, input op, input client_id, input client_weight,
                input ready_mask, output ready);
endinterface

@@ rtl/core/wfsa_rsp_if.sv @@
// result channel of the weighted fair slot arbiter
// depends on wfsa_pkg
interface wfsa_rsp_if;
  logic                          valid;
  logic                          ready;
  wfsa_pkg::status_t             status;
  wfsa_pkg::slot_idx_t           slot_index;
  logic [wfsa_pkg::CLIENT_W-1:0] chosen_client;

  modport source (output valid, output status, output slot_index, output chosen_client,
                  input ready);
  modport sink (input valid, input status, input slot_index, input chosen_client,
                output ready);
endinterface

@@ rtl/core/wfsa_slot_mem.sv @@
// slot table memory: one read and one write port, registered read data
// valid bits per slot so that an empty slot reads as all zero; depends on wfsa_pkg
module wfsa_slot_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wfsa_pkg::mem_req_t                req,
  output wfsa_pkg::slot_entry_t             rd_data,
  output logic [wfsa_pkg::NUM_SLOTS-1:0]    slot_valid
);

  wfsa_pkg::slot_entry_t              mem_r [wfsa_pkg::NUM_SLOTS];
  logic [wfsa_pkg::NUM_SLOTS-1:0]     valid_r;
  wfsa_pkg::slot_entry_t              rd_data_r;
  logic                               rd_vld_r;

  // storage array and read data register
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  // per-slot valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= req.wr_valid;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  // an empty slot reads as all zero
  assign rd_data    = rd_vld_r ? rd_data_r : '0;
  assign slot_valid = valid_r;

endmodule

@@ rtl/core/wfsa_div.sv @@
// bit-serial restoring divider for the slice charge, one quotient bit per cycle
// depends on wfsa_pkg
module wfsa_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wfsa_pkg::div_req_t              req,
  output logic                            done,
  output logic [wfsa_pkg::SLICE_W-1:0]    quotient
);

  logic [wfsa_pkg::SLICE_W-1:0]   q_r;
  logic [wfsa_pkg::WEIGHT_W-1:0]  rem_r;
  logic [wfsa_pkg::WEIGHT_W-1:0]  div_r;
  wfsa_pkg::div_cnt_t             cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [wfsa_pkg::WEIGHT_W:0]    shifted;
  logic [wfsa_pkg::WEIGHT_W+1:0]  trial;

  // shift in the next dividend bit and try a subtract
  assign shifted = {rem_r, q_r[wfsa_pkg::SLICE_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, div_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == wfsa_pkg::DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      if (!trial[wfsa_pkg::WEIGHT_W+1]) begin
        rem_r <= trial[wfsa_pkg::WEIGHT_W-1:0];
        q_r   <= {q_r[wfsa_pkg::SLICE_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[wfsa_pkg::WEIGHT_W-1:0];
        q_r   <= {q_r[wfsa_pkg::SLICE_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/core/wfsa_ctrl.sv @@
// request sequencer: slot scan over the memory, read-modify-write, global time
// and the result register; depends on wfsa_pkg
module wfsa_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wfsa_pkg::op_t                   in_op,
  input  logic [wfsa_pkg::CLIENT_W-1:0]   in_client_id,
  input  logic [wfsa_pkg::WEIGHT_W-1:0]   in_client_weight,
  input  logic [wfsa_pkg::READY_W-1:0]    in_ready_mask,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wfsa_pkg::status_t               out_status,
  output wfsa_pkg::slot_idx_t             out_slot_index,
  output logic [wfsa_pkg::CLIENT_W-1:0]   out_chosen_client,
  input  logic [wfsa_pkg::SLICE_W-1:0]    slice_len,
  input  logic                            arb_en,
  output wfsa_pkg::mem_req_t              mem_req,
  input  wfsa_pkg::slot_entry_t           rd_data,
  input  logic [wfsa_pkg::NUM_SLOTS-1:0]  slot_valid,
  output wfsa_pkg::div_req_t              div_req,
  input  logic                            div_done,
  input  logic [wfsa_pkg::SLICE_W-1:0]    div_quot
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  wfsa_pkg::op_t                 op_r, op_nxt;
  logic [wfsa_pkg::CLIENT_W-1:0] id_r, id_nxt;
  logic [wfsa_pkg::WEIGHT_W-1:0] w_r, w_nxt;
  logic [wfsa_pkg::READY_W-1:0]  rdy_r, rdy_nxt;
  wfsa_pkg::slot_idx_t           cnt_r, cnt_nxt;
  logic                          found_r, found_nxt;
  wfsa_pkg::slot_idx_t           best_idx_r, best_idx_nxt;
  wfsa_pkg::slot_entry_t         best_r, best_nxt;
  logic [wfsa_pkg::VTIME_W-1:0]  gvt_r, gvt_nxt;
  wfsa_pkg::slot_idx_t           wb_addr_r, wb_addr_nxt;
  wfsa_pkg::slot_entry_t         wb_data_r, wb_data_nxt;
  logic                          wb_valid_r, wb_valid_nxt;
  wfsa_pkg::status_t             res_status_r, res_status_nxt;
  wfsa_pkg::slot_idx_t           res_idx_r, res_idx_nxt;
  logic [wfsa_pkg::CLIENT_W-1:0] res_client_r, res_client_nxt;
  logic                          out_valid_r, out_valid_nxt;
  wfsa_pkg::status_t             out_status_r, out_status_nxt;
  wfsa_pkg::slot_idx_t           out_idx_r, out_idx_nxt;
  logic [wfsa_pkg::CLIENT_W-1:0] out_client_r, out_client_nxt;

  logic                          accept;
  logic                          free_hit;
  wfsa_pkg::slot_idx_t           free_idx;
  logic                          id_hit;
  logic                          better;
  logic [wfsa_pkg::VTIME_W-1:0]  vt_diff;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // lowest empty slot for attach
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = wfsa_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_hit = 1'b1;
        free_idx = wfsa_pkg::slot_idx_t'(i);
      end
    end
  end

  // compare of the slot just read
  assign id_hit  = (rd_data.client == id_r);
  assign better  = (rd_data.client != '0) && rdy_r[cnt_r]
                   && (!found_r || (rd_data.vtime < best_r.vtime));
  assign vt_diff = gvt_r - best_r.vtime;

  // memory and divider requests
  always_comb begin
    mem_req          = '0;
    mem_req.rd_en    = (state_r == S_RD);
    mem_req.rd_addr  = cnt_r;
    mem_req.wr_en    = (state_r == S_WB);
    mem_req.wr_addr  = wb_addr_r;
    mem_req.wr_valid = wb_valid_r;
    mem_req.wr_data  = wb_data_r;
    div_req.start    = (state_r == S_CHK) && found_r;
    div_req.dividend = slice_len;
    div_req.divisor  = (best_r.weight == '0) ? wfsa_pkg::WEIGHT_W'(1) : best_r.weight;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    w_nxt          = w_r;
    rdy_nxt        = rdy_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    gvt_nxt        = gvt_r;
    wb_addr_nxt    = wb_addr_r;
    wb_data_nxt    = wb_data_r;
    wb_valid_nxt   = wb_valid_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_client_nxt = res_client_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_client_nxt = out_client_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_op;
          id_nxt         = in_client_id;
          w_nxt          = in_client_weight;
          rdy_nxt        = in_ready_mask;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          res_status_nxt = wfsa_pkg::ST_NONE;
          res_idx_nxt    = '0;
          res_client_nxt = '0;
          if (in_op == wfsa_pkg::OP_DISPATCH) begin
            state_nxt = arb_en ? S_RD : S_RESP;
          end else if (in_client_id == '0) begin
            state_nxt = S_RESP;
          end else if (in_op == wfsa_pkg::OP_ATTACH) begin
            if (!free_hit) begin
              res_status_nxt = wfsa_pkg::ST_NO_SPACE;
              state_nxt      = S_RESP;
            end else begin
              wb_addr_nxt    = free_idx;
              wb_data_nxt    = '{client: in_client_id, weight: in_client_weight,
                                 vtime: gvt_r};
              wb_valid_nxt   = 1'b1;
              res_status_nxt = wfsa_pkg::ST_DONE;
              res_idx_nxt    = free_idx;
              state_nxt      = S_WB;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (op_r == wfsa_pkg::OP_DISPATCH) begin
          if (better) begin
            found_nxt    = 1'b1;
            best_idx_nxt = cnt_r;
            best_nxt     = rd_data;
          end
          if (cnt_r == wfsa_pkg::LAST_SLOT) begin
            state_nxt = S_CHK;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_RD;
          end
        end else if (id_hit) begin
          res_status_nxt = wfsa_pkg::ST_DONE;
          res_idx_nxt    = cnt_r;
          wb_addr_nxt    = cnt_r;
          if (op_r == wfsa_pkg::OP_DETACH) begin
            wb_data_nxt  = '0;
            wb_valid_nxt = 1'b0;
          end else begin
            wb_data_nxt  = '{client: rd_data.client, weight: w_r, vtime: rd_data.vtime};
            wb_valid_nxt = 1'b1;
          end
          state_nxt = S_WB;
        end else if (cnt_r == wfsa_pkg::LAST_SLOT) begin
          state_nxt = S_RESP;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_CHK: begin
        state_nxt = found_r ? S_DIV : S_RESP;
      end
      S_DIV: begin
        if (div_done) begin
          // raise global time on a wrapping compare
          if (vt_diff[wfsa_pkg::VTIME_W-1]) begin
            gvt_nxt = best_r.vtime;
          end
          wb_addr_nxt    = best_idx_r;
          wb_data_nxt    = '{client: best_r.client, weight: best_r.weight,
                             vtime: best_r.vtime + wfsa_pkg::VTIME_W'(div_quot)};
          wb_valid_nxt   = 1'b1;
          res_status_nxt = wfsa_pkg::ST_DONE;
          res_idx_nxt    = best_idx_r;
          res_client_nxt = best_r.client;
          state_nxt      = S_WB;
        end
      end
      S_WB: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_client_nxt = res_client_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gvt_r       <= '0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gvt_r       <= gvt_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    w_r          <= w_nxt;
    rdy_r        <= rdy_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    wb_addr_r    <= wb_addr_nxt;
    wb_data_r    <= wb_data_nxt;
    wb_valid_r   <= wb_valid_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_client_r <= res_client_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_client_r <= out_client_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_index    = out_idx_r;
  assign out_chosen_client = out_client_r;

endmodule

@@ rtl/core/weighted_fair_slot_arbiter_core.sv @@
// Weighted fair slot arbiter core.
// in_req carries one request (attach, detach, set weight or dispatch) under a
// valid/ready handshake; out_rsp returns exactly one result per request with
// status, slot index and, for a dispatch, the chosen client id.
// cfg_we/cfg_idx/cfg_wdata write slice_length (index 0) and arbiter_enable
// (index 1); write them only while no request is in flight.
// One request is worked on at a time. The slot table sits in a one-port-read
// memory and is scanned one slot at a time, each slot read, then compared.
// Attach: with a slot free, the entry is written to the lowest empty one, then
// the result goes out. Detach and set weight: scan up to a match, then write.
// Dispatch: 8-slot scan, then a 30-step serial divide of the slice by the
// weight; one that picks nothing skips the divide, one disabled skips the scan.
// Reset empties every slot, clears the global virtual time and loads the
// registers with slice 700000 and the arbiter enabled.
// A result waits in the output register while the receiver stalls; a new
// request is still taken, but its result is held back until the register frees.
`include "weighted_fair_slot_arbiter_core_assert.svh"
module weighted_fair_slot_arbiter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  wfsa_req_if.sink                        in_req,
  wfsa_rsp_if.source                      out_rsp,
  input  logic                            cfg_we,
  input  wfsa_pkg::cfg_idx_t              cfg_idx,
  input  logic [wfsa_pkg::SLICE_W-1:0]    cfg_wdata
);

  logic [wfsa_pkg::SLICE_W-1:0]   slice_r;
  logic                           enable_r;
  wfsa_pkg::mem_req_t             mem_req;
  wfsa_pkg::slot_entry_t          rd_data;
  logic [wfsa_pkg::NUM_SLOTS-1:0] slot_valid;
  wfsa_pkg::div_req_t             div_req;
  logic                           div_done;
  logic [wfsa_pkg::SLICE_W-1:0]   div_quot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r  <= wfsa_pkg::SLICE_RESET;
      enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        wfsa_pkg::CFG_SLICE:  slice_r  <= cfg_wdata;
        wfsa_pkg::CFG_ENABLE: enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // slot table
  wfsa_slot_mem u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (mem_req),
    .rd_data    (rd_data),
    .slot_valid (slot_valid)
  );

  // slice divider
  wfsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer
  wfsa_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_req.valid),
    .in_ready          (in_req.ready),
    .in_op             (in_req.op),
    .in_client_id      (in_req.client_id),
    .in_client_weight  (in_req.client_weight),
    .in_ready_mask     (in_req.ready_mask),
    .out_valid         (out_rsp.valid),
    .out_ready         (out_rsp.ready),
    .out_status        (out_rsp.status),
    .out_slot_index    (out_rsp.slot_index),
    .out_chosen_client (out_rsp.chosen_client),
    .slice_len         (slice_r),
    .arb_en            (enable_r),
    .mem_req           (mem_req),
    .rd_data           (rd_data),
    .slot_valid        (slot_valid),
    .div_req           (div_req),
    .div_done          (div_done),
    .div_quot          (div_quot)
  );

  // one request in flight at a time
  `WFSA_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready)
  // a failed request reports slot 0 and no client
  `WFSA_ASSERT_IMP(a_fail_clean, clk, rst_n,
    out_rsp.valid && (out_rsp.status != wfsa_pkg::ST_DONE),
    (out_rsp.slot_index == '0) && (out_rsp.chosen_client == '0))
  // no table access in the cycle a charge starts
  `WFSA_ASSERT_IMP(a_no_wr_on_start, clk, rst_n, div_req.start, !mem_req.wr_en && !mem_req.rd_en)

endmodule

@@ tb/tb.sv @@
// self-checking testbench for weighted_fair_slot_arbiter_core
// depends on wfsa_pkg, wfsa_req_if, wfsa_rsp_if and the core rtl
// predicts each result from a local model of the slot table and compares in order
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wfsa_pkg::*;

  typedef struct {
    op_t                 op;
    logic [CLIENT_W-1:0] client_id;
    logic [WEIGHT_W-1:0] weight;
    logic [READY_W-1:0]  mask;
  } request_t;

  typedef struct {
    status_t             status;
    slot_idx_t           slot;
    logic [CLIENT_W-1:0] client;
  } result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_idx;
  logic [SLICE_W-1:0]  cfg_wdata;

  wfsa_req_if req_ch();
  wfsa_rsp_if rsp_ch();

  weighted_fair_slot_arbiter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // model of the slot table and registers
  logic [CLIENT_W-1:0] slot_owner [NUM_SLOTS];
  logic [WEIGHT_W-1:0] slot_share [NUM_SLOTS];
  logic [VTIME_W-1:0]  slot_clock [NUM_SLOTS];
  logic [VTIME_W-1:0]  fair_clock;
  logic [SLICE_W-1:0]  charge_slice;
  logic                arb_on;

  request_t            req_backlog [$];
  result_t             rsp_due [$];
  logic [CLIENT_W-1:0] id_pool [10];

  int unsigned errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_dispatched = 0;
  int unsigned n_no_space = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;

  // sender and receiver pacing
  request_t    tx_item;
  int unsigned tx_gap;
  int unsigned tx_mode_left;
  bit          tx_calm;
  int unsigned rx_stall;
  int unsigned rx_hold;
  int unsigned rx_mode_left;
  int unsigned rx_pause;
  bit          rx_calm;
  result_t     want;

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one, none in calm stretches
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apply one request to the model and return the result it yields
  function automatic result_t serve_request(request_t r);
    result_t             res;
    int                  pick;
    logic [VTIME_W-1:0]  lag;
    logic [WEIGHT_W-1:0] eff_w;
    res.status = ST_NONE;
    res.slot   = '0;
    res.client = '0;
    pick       = -1;
    if (r.op == OP_DISPATCH) begin
      if (!arb_on) return res;
      // lowest virtual time among occupied ready slots, lowest index on ties
      for (int k = 0; k < NUM_SLOTS && k < READY_W; k++) begin
        if (slot_owner[k] != '0 && r.mask[k] &&
            (pick < 0 || slot_clock[k] < slot_clock[pick]))
          pick = k;
      end
      if (pick < 0) return res;
      eff_w = (slot_share[pick] == '0) ? WEIGHT_W'(1) : slot_share[pick];
      // wrapping compare before raising the global time
      lag = fair_clock - slot_clock[pick];
      if (lag[VTIME_W-1]) fair_clock = slot_clock[pick];
      slot_clock[pick] = slot_clock[pick] + VTIME_W'(charge_slice / eff_w);
      res.status = ST_DONE;
      res.slot   = slot_idx_t'(pick);
      res.client = slot_owner[pick];
      return res;
    end
    // id zero marks an empty slot and is never served
    if (r.client_id == '0) return res;
    if (r.op == OP_ATTACH) begin
      for (int k = NUM_SLOTS - 1; k >= 0; k--)
        if (slot_owner[k] == '0) pick = k;
      if (pick < 0) begin
        res.status = ST_NO_SPACE;
        return res;
      end
      slot_owner[pick] = r.client_id;
      slot_share[pick] = r.weight;
      slot_clock[pick] = fair_clock;
    end else begin
      for (int k = NUM_SLOTS - 1; k >= 0; k--)
        if (slot_owner[k] == r.client_id) pick = k;
      if (pick < 0) return res;
      if (r.op == OP_DETACH) begin
        slot_owner[pick] = '0;
        slot_share[pick] = '0;
        slot_clock[pick] = '0;
      end else begin
        slot_share[pick] = r.weight;
      end
    end
    res.status = ST_DONE;
    res.slot   = slot_idx_t'(pick);
    return res;
  endfunction

  // random request, mostly on a small pool of ids so that lookups hit
  function automatic request_t draw_request();
    request_t    r;
    int unsigned roll;
    int unsigned wroll;
    roll  = $urandom_range(0, 99);
    wroll = $urandom_range(0, 9);
    r.mask      = ($urandom_range(0, 1) != 0) ? 8'hFF : READY_W'($urandom);
    r.client_id = id_pool[$urandom_range(0, 9)];
    if (wroll < 6)      r.weight = WEIGHT_W'($urandom_range(0, 16));
    else if (wroll < 9) r.weight = WEIGHT_W'($urandom_range(0, 10000));
    else                r.weight = WEIGHT_W'($urandom_range(0, 16383));
    if (roll < 45) begin
      r.op = OP_DISPATCH;
    end else if (roll < 67) begin
      r.op = OP_ATTACH;
      if ($urandom_range(0, 9) < 3) r.client_id = {$urandom, $urandom};
    end else if (roll < 81) begin
      r.op = OP_DETACH;
    end else if (roll < 95) begin
      r.op = OP_SET_WEIGHT;
    end else begin
      // noise: id zero or an id that is most likely absent
      r.op        = op_t'($urandom_range(0, 2));
      r.client_id = ($urandom_range(0, 1) != 0) ? '0 : {$urandom, $urandom};
    end
    return r;
  endfunction

  task automatic queue_req(op_t op, logic [CLIENT_W-1:0] id, int unsigned w,
                           logic [READY_W-1:0] mask);
    request_t r;
    r.op        = op;
    r.client_id = id;
    r.weight    = WEIGHT_W'(w);
    r.mask      = mask;
    req_backlog.push_back(r);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [SLICE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // sampled on the falling edge, clear of the rising-edge updates
  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || rsp_due.size() != 0);
  endtask

  task automatic run_phase(logic [SLICE_W-1:0] slice, bit enable, int unsigned count,
                           bit squeeze);
    write_reg(CFG_SLICE, slice);
    write_reg(CFG_ENABLE, SLICE_W'(enable));
    @(negedge clk);
    if (squeeze) hold_asks++;
    repeat (count) req_backlog.push_back(draw_request());
    wait_idle();
  endtask

  task automatic check_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      tx_gap       <= 0;
      tx_mode_left <= 0;
      tx_calm      <= 1'b0;
    end else begin
      if (tx_mode_left == 0) begin
        tx_calm      <= ~tx_calm;
        tx_mode_left <= $urandom_range(20, 300);
      end else begin
        tx_mode_left <= tx_mode_left - 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // request still on offer
      end else if (tx_gap != 0) begin
        req_ch.valid <= 1'b0;
        tx_gap       <= tx_gap - 1;
      end else if (req_backlog.size() != 0) begin
        tx_item              = req_backlog.pop_front();
        req_ch.valid         <= 1'b1;
        req_ch.op            <= tx_item.op;
        req_ch.client_id     <= tx_item.client_id;
        req_ch.client_weight <= tx_item.weight;
        req_ch.ready_mask    <= tx_item.mask;
        tx_gap               <= pick_gap(tx_calm);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // model update on register writes and accepted requests
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_owner[k] = '0;
        slot_share[k] = '0;
        slot_clock[k] = '0;
      end
      fair_clock   = '0;
      charge_slice = SLICE_RESET;
      arb_on       = 1'b1;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SLICE) charge_slice = cfg_wdata;
        else if (cfg_idx == CFG_ENABLE) arb_on = cfg_wdata[0];
      end
      if (req_ch.valid && req_ch.ready) begin
        r.op        = req_ch.op;
        r.client_id = req_ch.client_id;
        r.weight    = req_ch.client_weight;
        r.mask      = req_ch.ready_mask;
        rsp_due.push_back(serve_request(r));
        n_accepted++;
      end
    end
  end

  // result receiver with random stalls and the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      rx_stall     <= 0;
      rx_hold      <= 0;
      rx_mode_left <= 0;
      rx_calm      <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_calm      <= ~rx_calm;
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (rx_hold != 0) begin
        rsp_ch.ready <= 1'b0;
        rx_hold      <= rx_hold - 1;
      end else if (hold_done != hold_asks) begin
        rsp_ch.ready <= 1'b0;
        rx_hold      <= 400;
        hold_done    <= hold_done + 1;
      end else if (rx_stall != 0) begin
        rsp_ch.ready <= 1'b0;
        rx_stall     <= rx_stall - 1;
      end else begin
        rx_pause     = pick_gap(rx_calm);
        rsp_ch.ready <= (rx_pause == 0);
        rx_stall     <= (rx_pause == 0) ? 0 : rx_pause - 1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d slot %0d client %h",
                 $time, rsp_ch.status, rsp_ch.slot_index, rsp_ch.chosen_client);
      end else begin
        want = rsp_due.pop_front();
        n_checked++;
        if (want.status == ST_DONE && want.client != '0) n_dispatched++;
        if (want.status == ST_NO_SPACE) n_no_space++;
        check_field("status", 64'(want.status), 64'(rsp_ch.status));
        check_field("slot_index", 64'(want.slot), 64'(rsp_ch.slot_index));
        check_field("chosen_client", want.client, rsp_ch.chosen_client);
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_SLICE;
    cfg_wdata            = '0;
    req_ch.valid         = 1'b0;
    req_ch.op            = OP_ATTACH;
    req_ch.client_id     = '0;
    req_ch.client_weight = '0;
    req_ch.ready_mask    = '0;
    rsp_ch.ready         = 1'b0;
    id_pool[0] = '1;
    id_pool[1] = 64'd1;
    for (int k = 2; k < 10; k++) begin
      id_pool[k] = {$urandom, $urandom};
      if (id_pool[k] == '0) id_pool[k] = 64'(k);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, id zero and unknown ids
    queue_req(OP_DISPATCH, '0, 0, 8'hFF);
    queue_req(OP_ATTACH, '0, 5, 8'h00);
    queue_req(OP_DETACH, '0, 0, 8'h00);
    queue_req(OP_SET_WEIGHT, '0, 3, 8'h00);
    queue_req(OP_DETACH, id_pool[8], 0, 8'h00);
    queue_req(OP_SET_WEIGHT, id_pool[8], 9, 8'h00);
    // fill every slot, with a duplicate id and extreme weights, then overflow
    queue_req(OP_ATTACH, id_pool[2], 0, 8'h00);
    queue_req(OP_ATTACH, id_pool[3], 16383, 8'h00);
    queue_req(OP_ATTACH, id_pool[1], 1, 8'h00);
    queue_req(OP_ATTACH, id_pool[0], 10000, 8'h00);
    queue_req(OP_ATTACH, id_pool[2], 5, 8'h00);
    queue_req(OP_ATTACH, id_pool[4], 2, 8'h00);
    queue_req(OP_ATTACH, id_pool[5], 3, 8'h00);
    queue_req(OP_ATTACH, id_pool[6], 7, 8'h00);
    queue_req(OP_ATTACH, id_pool[7], 4, 8'h00);
    // dispatch with full, empty and single-bit masks
    queue_req(OP_DISPATCH, '0, 0, 8'hFF);
    queue_req(OP_DISPATCH, '0, 0, 8'h00);
    queue_req(OP_DISPATCH, '0, 0, 8'h80);
    queue_req(OP_DISPATCH, '0, 0, 8'h01);
    // first match wins for set weight and detach
    queue_req(OP_SET_WEIGHT, id_pool[2], 4, 8'h00);
    queue_req(OP_DETACH, id_pool[2], 0, 8'h00);
    queue_req(OP_DETACH, id_pool[2], 0, 8'h00);
    queue_req(OP_DISPATCH, '0, 0, 8'hFF);
    queue_req(OP_ATTACH, id_pool[0], 16383, 8'h00);
    wait_idle();

    // disabled arbiter
    write_reg(CFG_ENABLE, SLICE_W'(0));
    @(negedge clk);
    queue_req(OP_DISPATCH, '0, 0, 8'hFF);
    wait_idle();

    // random phases over several register settings
    run_phase(SLICE_W'(1), 1'b1, 300, 1'b0);
    run_phase('1, 1'b1, 300, 1'b1);
    run_phase('0, 1'b1, 200, 1'b0);
    run_phase(SLICE_W'(1_000_000_000), 1'b0, 60, 1'b0);
    run_phase(SLICE_W'(1_000_000_000), 1'b1, 400, 1'b0);
    run_phase(SLICE_W'($urandom_range(1, 5000)), 1'b1, 340, 1'b0);
    run_phase(SLICE_RESET, 1'b1, 300, 1'b1);

    // let any stray result show up
    repeat (60) @(posedge clk);
    $display("covered %0d requests and %0d results over eight register settings",
             n_accepted, n_checked);
    $display("%0d dispatches picked a slot, %0d attaches found the table full",
             n_dispatched, n_no_space);
    if (errors == 0 && rsp_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (rsp_due.size() != 0)
        $display("%0d expected results never arrived", rsp_due.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", rsp_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
